// ----- design/sha1_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the SHA-1 hash engine: controller states,
// command and status records, round constants and initial hash words.
// ----------------------------------------------------------------------------
package sha1_pkg;

   localparam int unsigned NUM_WORDS = 5;

   localparam logic [31:0] INIT_H [NUM_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_CH   = 32'h5A827999;
   localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
   localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

   localparam logic [5:0] FILL_LAST     = 6'd63;
   localparam logic [5:0] FILL_LEN_POS  = 6'd56;
   localparam logic [6:0] LAST_ROUND    = 7'd79;
   localparam logic [6:0] PHASE1_START  = 7'd20;
   localparam logic [6:0] PHASE2_START  = 7'd40;
   localparam logic [6:0] PHASE3_START  = 7'd60;
   localparam logic [2:0] LAST_WORD_IDX = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD_MARK,
      S_PAD_ZERO,
      S_PAD_LEN,
      S_ROUND,
      S_ADD,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef enum logic [1:0] {
      PH_CH,
      PH_PAR1,
      PH_MAJ,
      PH_PAR2
   } phase_type;

   typedef struct packed {
      logic         shift_en;
      byte_src_type shift_src;
      logic [2:0]   len_idx;
      logic         count_byte;
      logic         init_work;
      logic         round_en;
      phase_type    phase;
      logic         add_en;
      logic         out_load;
      logic [2:0]   out_idx;
      logic         out_last;
      logic         reinit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ----- design/sha1_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1 channel interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- design/sha1_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: byte fill, padding, round count and digest read-out.
// ----------------------------------------------------------------------------
module sha1_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    byte_present,
   input  logic                    end_of_message,
   input  sha1_pkg::dp_status_type status,
   output logic                    req_ready,
   output sha1_pkg::ctrl_cmd_type  cmd
);
   import sha1_pkg::*;

   state_type  state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [6:0] rnd_ff, rnd_in;
   logic [2:0] out_cnt_ff, out_cnt_in;
   logic       end_pend_ff, end_pend_in;
   logic       pad_ff, pad_in;
   logic       final_ff, final_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_ff     <= '0;
         rnd_ff      <= '0;
         out_cnt_ff  <= '0;
         end_pend_ff <= 1'b0;
         pad_ff      <= 1'b0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         rnd_ff      <= rnd_in;
         out_cnt_ff  <= out_cnt_in;
         end_pend_ff <= end_pend_in;
         pad_ff      <= pad_in;
         final_ff    <= final_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (byte_present && fill_ff == FILL_LAST) state_in = S_ROUND;
               else if (end_of_message)                  state_in = S_PAD_MARK;
            end
         end
         S_PAD_MARK: begin
            state_in = (fill_ff == FILL_LAST) ? S_ROUND : S_PAD_ZERO;
         end
         S_PAD_ZERO: begin
            if (fill_ff == FILL_LEN_POS)   state_in = S_PAD_LEN;
            else if (fill_ff == FILL_LAST) state_in = S_ROUND;
         end
         S_PAD_LEN: begin
            if (fill_ff == FILL_LAST) state_in = S_ROUND;
         end
         S_ROUND: begin
            if (rnd_ff == LAST_ROUND) state_in = S_ADD;
         end
         S_ADD: begin
            if (final_ff)         state_in = S_OUT;
            else if (pad_ff)      state_in = S_PAD_ZERO;
            else if (end_pend_ff) state_in = S_PAD_MARK;
            else                  state_in = S_IDLE;
         end
         S_OUT: begin
            if (status.out_free && out_cnt_ff == LAST_WORD_IDX) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands and counters
   always_comb begin
      cmd         = '0;
      fill_in     = fill_ff;
      rnd_in      = rnd_ff;
      out_cnt_in  = out_cnt_ff;
      end_pend_in = end_pend_ff;
      pad_in      = pad_ff;
      final_in    = final_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               end_pend_in = end_of_message;
               pad_in      = 1'b0;
               final_in    = 1'b0;
               if (byte_present) begin
                  cmd.shift_en   = 1'b1;
                  cmd.shift_src  = SRC_DATA;
                  cmd.count_byte = 1'b1;
                  fill_in        = fill_ff + 6'd1;
                  if (fill_ff == FILL_LAST) begin
                     cmd.init_work = 1'b1;
                     rnd_in        = '0;
                  end
               end
            end
         end
         S_PAD_MARK: begin
            pad_in        = 1'b1;
            cmd.shift_en  = 1'b1;
            cmd.shift_src = SRC_MARK;
            fill_in       = fill_ff + 6'd1;
            if (fill_ff == FILL_LAST) begin
               cmd.init_work = 1'b1;
               rnd_in        = '0;
            end
         end
         S_PAD_ZERO: begin
            if (fill_ff != FILL_LEN_POS) begin
               cmd.shift_en  = 1'b1;
               cmd.shift_src = SRC_ZERO;
               fill_in       = fill_ff + 6'd1;
               if (fill_ff == FILL_LAST) begin
                  cmd.init_work = 1'b1;
                  rnd_in        = '0;
               end
            end
         end
         S_PAD_LEN: begin
            cmd.shift_en  = 1'b1;
            cmd.shift_src = SRC_LEN;
            cmd.len_idx   = fill_ff[2:0];
            fill_in       = fill_ff + 6'd1;
            if (fill_ff == FILL_LAST) begin
               cmd.init_work = 1'b1;
               rnd_in        = '0;
               final_in      = 1'b1;
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            if (rnd_ff < PHASE1_START)      cmd.phase = PH_CH;
            else if (rnd_ff < PHASE2_START) cmd.phase = PH_PAR1;
            else if (rnd_ff < PHASE3_START) cmd.phase = PH_MAJ;
            else                            cmd.phase = PH_PAR2;
            rnd_in = rnd_ff + 7'd1;
         end
         S_ADD: begin
            cmd.add_en = 1'b1;
            out_cnt_in = '0;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_idx  = out_cnt_ff;
               cmd.out_last = (out_cnt_ff == LAST_WORD_IDX);
               out_cnt_in   = out_cnt_ff + 3'd1;
               if (out_cnt_ff == LAST_WORD_IDX) begin
                  cmd.reinit  = 1'b1;
                  end_pend_in = 1'b0;
                  pad_in      = 1'b0;
                  final_in    = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   a_round_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && rnd_ff == LAST_ROUND) |=> (state_ff == S_ADD))
      else $error("round sequence did not end in the add step");

   a_final_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD && final_ff) |=> (state_ff == S_OUT))
      else $error("final block not followed by digest read-out");

   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAD_LEN) |-> (fill_ff[5:3] == 3'b111))
      else $error("length bytes outside the last eight block positions");

   a_out_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (fill_ff == '0 && out_cnt_ff <= LAST_WORD_IDX))
      else $error("digest read-out with partial block or bad word count");

endmodule

// ----- design/sha1_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: block shift register doubling as message schedule, round
// unit, chaining value, bit length and digest output register.
// ----------------------------------------------------------------------------
module sha1_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  sha1_pkg::ctrl_cmd_type  cmd,
   input  logic [7:0]              data_byte,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [31:0]             digest_word,
   output logic [2:0]              word_index,
   output logic                    last_word,
   output sha1_pkg::dp_status_type status
);
   import sha1_pkg::*;

   logic [511:0] blk_ff, blk_in;
   logic [31:0]  h_ff [NUM_WORDS];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [63:0]  len_ff;
   logic         valid_ff;
   logic [31:0]  word_ff;
   logic [2:0]   idx_ff;
   logic         last_ff;

   logic [7:0]   shift_byte;
   logic [63:0]  len_shifted;
   logic [31:0]  w_top, w_mix, w_new;
   logic [31:0]  f_val, k_val, t_val;

   // window holds W[t..t+15], oldest word in the top bits
   assign w_top = blk_ff[511:480];
   assign w_mix = blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ w_top;
   assign w_new = {w_mix[30:0], w_mix[31]};

   assign len_shifted = len_ff >> {~cmd.len_idx, 3'b000};

   always_comb begin
      case (cmd.shift_src)
         SRC_DATA: shift_byte = data_byte;
         SRC_MARK: shift_byte = PAD_MARK_BYTE;
         SRC_ZERO: shift_byte = 8'h00;
         SRC_LEN:  shift_byte = len_shifted[7:0];
         default:  shift_byte = 8'h00;
      endcase
   end

   always_comb begin
      if (cmd.shift_en)      blk_in = {blk_ff[503:0], shift_byte};
      else if (cmd.round_en) blk_in = {blk_ff[479:0], w_new};
      else                   blk_in = blk_ff;
   end

   always_comb begin
      case (cmd.phase)
         PH_CH: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            k_val = K_CH;
         end
         PH_PAR1: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_PAR1;
         end
         PH_MAJ: begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = K_MAJ;
         end
         PH_PAR2: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_PAR2;
         end
         default: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_PAR2;
         end
      endcase
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_top;

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (cmd.init_work) begin
         a_ff <= h_ff[0];
         b_ff <= h_ff[1];
         c_ff <= h_ff[2];
         d_ff <= h_ff[3];
         e_ff <= h_ff[4];
      end else if (cmd.round_en) begin
         a_ff <= t_val;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
      if (cmd.out_load) begin
         word_ff <= h_ff[cmd.out_idx];
         idx_ff  <= cmd.out_idx;
         last_ff <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff     <= INIT_H;
         len_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.reinit) begin
            h_ff   <= INIT_H;
            len_ff <= '0;
         end else begin
            if (cmd.add_en) begin
               h_ff[0] <= h_ff[0] + a_ff;
               h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff;
               h_ff[3] <= h_ff[3] + d_ff;
               h_ff[4] <= h_ff[4] + e_ff;
            end
            if (cmd.count_byte) len_ff <= len_ff + 64'd8;
         end
         if (cmd.out_load)       valid_ff <= 1'b1;
         else if (rsp_ready)     valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !valid_ff || rsp_ready;
   assign rsp_valid       = valid_ff;
   assign digest_word     = word_ff;
   assign word_index      = idx_ff;
   assign last_word       = last_ff;

endmodule

// ----- design/sha1_hash_engine_top.sv -----
`timescale 1ns / 1ps
// Input: one byte per cycle while idle; every 64th byte starts 80 rounds plus the add.
// Compression: one round per cycle, using the block shift register as its
//   message schedule; no byte is taken while it runs.
// End of message: padding bytes, then each final block is compressed, then 5 digest
//   transactions, one per cycle while the sink is ready.
// Reset (synchronous, active high) loads H0..H4 and clears length, fill and valid.
// ----------------------------------------------------------------------------
// sha1_hash_engine_top
// SHA-1 engine over a byte stream: absorbs bytes, pads, compresses and
// returns the five digest words as separate transactions.
// ----------------------------------------------------------------------------
module sha1_hash_engine_top (
   input logic      clock,
   input logic      reset,
   sha1_req_if.sink   req_ch,
   sha1_rsp_if.source rsp_ch
);
   import sha1_pkg::*;

   // command and status records between sequencer and datapath
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The sequencer owns the fill, round and digest word counters; the bit length
   // counter is in the datapath. It only takes a new transaction while idle, so a
   // byte never lands in the block register while the schedule is running.
   sha1_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .byte_present   (req_ch.byte_present),
      .end_of_message (req_ch.end_of_message),
      .status         (status),
      .req_ready      (req_ch.ready),
      .cmd            (cmd)
   );

   // The datapath holds the 512-bit block register, which after the last
   // byte of a block is shifted one word per round to form W[t]. The digest
   // leaves through an output register, so the next message may start while
   // the final word still waits for the sink.
   sha1_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_ch.data_byte),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .digest_word (rsp_ch.digest_word),
      .word_index  (rsp_ch.word_index),
      .last_word   (rsp_ch.last_word),
      .status      (status)
   );

endmodule
